// ===== hdl/dsp_pkg.sv =====
// shared types, widths and constants of the duration string parser
// no dependencies
package dsp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SEC_W   = 64;
  localparam int unsigned SCALE_W = 25;
  localparam int unsigned HALF_W  = SEC_W / 2;
  localparam int unsigned LO_W    = HALF_W + SCALE_W;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [SCALE_W-1:0] SECS_SECOND = 25'd1;
  localparam logic [SCALE_W-1:0] SECS_MINUTE = 25'd60;
  localparam logic [SCALE_W-1:0] SECS_HOUR   = 25'd3600;
  localparam logic [SCALE_W-1:0] SECS_DAY    = 25'd86400;
  localparam logic [SCALE_W-1:0] SECS_WEEK   = 25'd604800;
  localparam logic [SCALE_W-1:0] SECS_YEAR   = 25'd31557600;
  localparam logic [SCALE_W-1:0] SECS_NONE   = 25'd0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  // one multiply-accumulate request from the scan stage
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               bad;
    logic [SEC_W-1:0]   operand;
    logic [SCALE_W-1:0] scale;
  } mac_req_t;

  // seconds per unit letter, zero for anything else
  function automatic logic [SCALE_W-1:0] unit_scale(input logic [CHAR_W-1:0] c);
    logic [SCALE_W-1:0] s;
    case (c)
      8'h73, 8'h53: s = SECS_SECOND;
      8'h6d, 8'h4d: s = SECS_MINUTE;
      8'h68, 8'h48: s = SECS_HOUR;
      8'h64, 8'h44: s = SECS_DAY;
      8'h77, 8'h57: s = SECS_WEEK;
      8'h79, 8'h59: s = SECS_YEAR;
      default:      s = SECS_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/dsp_scan.sv =====
// input register, character decode and running decimal number
// depends on dsp_pkg
module dsp_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       op,
  input  logic [dsp_pkg::CHAR_W-1:0] char_code,
  output dsp_pkg::mac_req_t          req,
  input  logic                       req_ready
);

  logic                       s1_vld;
  logic                       s1_op;
  logic [dsp_pkg::CHAR_W-1:0] s1_char;
  logic [dsp_pkg::SEC_W-1:0]  pending;
  logic                       bad;

  logic                         is_digit;
  logic [dsp_pkg::SCALE_W-1:0]  scale;
  logic                         need_mac;
  logic                         s1_go;
  logic [dsp_pkg::SEC_W-1:0]    digit;
  logic [dsp_pkg::SEC_W-1:0]    pending_next;

  always_comb begin
    is_digit = (s1_char >= dsp_pkg::CHAR_ZERO) && (s1_char <= dsp_pkg::CHAR_NINE);
    scale    = dsp_pkg::unit_scale(s1_char);
    digit    = {{(dsp_pkg::SEC_W-dsp_pkg::CHAR_W){1'b0}}, s1_char - dsp_pkg::CHAR_ZERO};
    // number * 10 + digit as shift-adds
    pending_next = (pending << 3) + (pending << 1) + digit;
    need_mac = (s1_op == dsp_pkg::OP_END) || (!bad && !is_digit && (scale != dsp_pkg::SECS_NONE));
    s1_go    = s1_vld && (!need_mac || req_ready);
    in_ready = !s1_vld || s1_go;

    req.vld     = s1_vld && need_mac;
    req.last    = (s1_op == dsp_pkg::OP_END);
    req.bad     = bad;
    req.operand = pending;
    // end item pushes the trailing number through as plain seconds
    req.scale   = (s1_op == dsp_pkg::OP_END) ? dsp_pkg::SECS_SECOND : scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      pending <= '0;
      bad     <= 1'b0;
    end else begin
      if (s1_go) begin
        if (s1_op == dsp_pkg::OP_END) begin
          pending <= '0;
          bad     <= 1'b0;
        end else if (!bad) begin
          if (is_digit) begin
            pending <= pending_next;
          end else if (scale != dsp_pkg::SECS_NONE) begin
            pending <= '0;
          end else begin
            bad <= 1'b1;
          end
        end
      end
      if (in_ready) begin
        s1_vld <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= op;
      s1_char <= char_code;
    end
  end

endmodule

// ===== hdl/dsp_accum.sv =====
// split 64 by 25 bit product, running total and result register
// depends on dsp_pkg
module dsp_accum (
  input  logic                      clk,
  input  logic                      rst,
  input  dsp_pkg::mac_req_t         req,
  output logic                      req_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic [dsp_pkg::SEC_W-1:0] seconds
);

  logic                        s2_vld;
  logic                        s2_last;
  logic                        s2_bad;
  logic [dsp_pkg::LO_W-1:0]    prod_lo;
  logic [dsp_pkg::HALF_W-1:0]  prod_hi;
  logic [dsp_pkg::SEC_W-1:0]   total;

  logic                        s2_go;
  logic                        load;
  logic [dsp_pkg::SEC_W-1:0]   sum;
  logic [dsp_pkg::LO_W-1:0]    lo_mul;
  logic [dsp_pkg::LO_W-1:0]    hi_mul;

  always_comb begin
    s2_go     = s2_vld && (!s2_last || !out_valid || out_ready);
    req_ready = !s2_vld || s2_go;
    load      = req.vld && req_ready;
    lo_mul    = req.operand[dsp_pkg::HALF_W-1:0] * req.scale;
    hi_mul    = req.operand[dsp_pkg::SEC_W-1:dsp_pkg::HALF_W] * req.scale;
    sum = total
        + {{(dsp_pkg::SEC_W-dsp_pkg::LO_W){1'b0}}, prod_lo}
        + {prod_hi, {dsp_pkg::HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld    <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s2_vld <= 1'b1;
      end else if (s2_go) begin
        s2_vld <= 1'b0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (s2_go) begin
        if (s2_last) begin
          total     <= '0;
          out_valid <= 1'b1;
        end else begin
          total <= sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_last <= req.last;
      s2_bad  <= req.bad;
      prod_lo <= lo_mul;
      // upper partial product only matters mod 2^64
      prod_hi <= hi_mul[dsp_pkg::HALF_W-1:0];
    end
    if (s2_go && s2_last) begin
      ok      <= !s2_bad;
      seconds <= s2_bad ? '0 : sum;
    end
  end

endmodule

// ===== hdl/duration_string_parser.sv =====
// duration string parser top level: scan stage and accumulate stage
// depends on dsp_pkg, dsp_scan, dsp_accum
//
// Takes one character of a duration text such as 1w2d3h4m5s per item, or an
// end item, and gives one result (ok, seconds) for each end item. An item is
// accepted in every cycle while results are taken; the per-character rate is
// set by the decimal number update in the scan stage. A result passes from
// the input register through the partial-product register to the result
// register, where the running total is added. The result register holds
// while out_ready is low, and the stages behind it keep accepting until they
// are full.
module duration_string_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic [dsp_pkg::CHAR_W-1:0] char_code,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      ok,
  output logic [dsp_pkg::SEC_W-1:0] seconds
);

  dsp_pkg::mac_req_t req;
  logic              req_ready;

  dsp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .char_code (char_code),
    .req       (req),
    .req_ready (req_ready)
  );

  dsp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_ready (req_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ok        (ok),
    .seconds   (seconds)
  );

endmodule

// ===== hdl/dsp_checker.sv =====
// port-level checks of the duration string parser, bound to the top level
// depends on dsp_pkg and duration_string_parser
module dsp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       op,
  input logic [dsp_pkg::CHAR_W-1:0] char_code,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       ok,
  input logic [dsp_pkg::SEC_W-1:0]  seconds
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(seconds))
    else $error("result changed while stalled");

  // an invalid string reports zero seconds
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> seconds == '0)
    else $error("invalid result with nonzero seconds");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an item taken right after reset cannot yet produce a result
  a_no_early: assert property (@(posedge clk)
    rst ##1 !rst |=> !out_valid)
    else $error("result appeared without an end item");

endmodule

bind duration_string_parser dsp_checker u_chk (.*);
